// ----- src/sts_pkg.sv -----
// Shared types, character codes and result layout for the s-expression token scanner.
package sts_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int OUT_W           = 16;
  localparam int MAX_RES         = 3;
  localparam int FIFO_DEPTH      = 4;
  localparam int PTR_W           = $clog2(FIFO_DEPTH);
  localparam int CNT_W           = PTR_W + 1;
  localparam int NUM_W           = $clog2(MAX_RES + 1);
  localparam logic [OUT_W-1:0] LINE_MAX = '1;

  typedef enum logic [2:0] {
    K_LPAREN = 3'd0,
    K_RPAREN = 3'd1,
    K_NUMBER = 3'd2,
    K_IDENT  = 3'd3,
    K_STRING = 3'd4,
    K_END    = 3'd5,
    K_UNTERM = 3'd6,
    K_UNEXP  = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] len;
    logic [OUT_W-1:0] line;
    logic             frac;
    logic             last;
  } res_t;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic ident_cont(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_QMARK);
  endfunction

  function automatic logic ident_start(input logic [7:0] c);
    return is_alpha(c) || (c == CH_PLUS) || (c == CH_STAR) || (c == CH_SLASH) ||
           (c == CH_LT) || (c == CH_GT) || (c == CH_EQ);
  endfunction

endpackage

// ----- src/sts_scan_core.sv -----
// Input register, token mode state and per-character result generation.
module sts_scan_core import sts_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       char_code_i,
  input  logic             end_of_text_i,
  input  logic             room_i,
  output logic [NUM_W-1:0] push_n_o,
  output res_t             push_data_o [MAX_RES]
);

  typedef enum logic [3:0] {
    M_IDLE, M_INT, M_DOT, M_FRAC, M_MINUS, M_IDENT, M_STRING, M_COMMENT, M_ERROR
  } mode_e;

  localparam int NCAND = 5;

  logic                   in_vld_q;
  logic [7:0]             char_q;
  logic                   eot_q;
  logic                   proc;
  logic                   accept;

  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] ts_q, ts_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OUT_W-1:0]       line_q, line_d;

  res_t                   cand  [NCAND];
  logic [NCAND-1:0]       cand_v;
  res_t                   slot  [MAX_RES];
  logic [2:0]             n;
  logic                   st_go;
  logic [OFFSET_BITS-1:0] p, q, one;

  function automatic res_t mk(input kind_e k, input logic [OFFSET_BITS-1:0] s,
                              input logic [OFFSET_BITS-1:0] l, input logic f,
                              input logic [OUT_W-1:0] ln);
    res_t r;
    r.kind  = k;
    r.start = OUT_W'(s);
    r.len   = OUT_W'(l);
    r.line  = ln;
    r.frac  = f;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] line_inc(input logic [OUT_W-1:0] l);
    return (l != LINE_MAX) ? l + 1'b1 : l;
  endfunction

  assign proc       = in_vld_q && room_i;
  assign in_stall_o = in_vld_q && !room_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign p   = pos_q;
  assign one = OFFSET_BITS'(1);
  assign q   = pos_q + one;

  always_comb begin
    mode_d = mode_q;
    ts_d   = ts_q;
    line_d = line_q;
    pos_d  = q;
    st_go  = 1'b0;
    cand_v = '0;
    for (int i = 0; i < NCAND; i++) cand[i] = '0;

    // current mode decides what this character closes
    unique case (mode_q)
      M_INT: begin
        if (is_digit(char_q)) begin
        end else if (char_q == CH_DOT) begin
          mode_d = M_DOT;
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk(K_NUMBER, ts_q, p - ts_q, 1'b0, line_q);
          st_go     = 1'b1;
        end
      end
      M_DOT: begin
        if (is_digit(char_q)) begin
          mode_d = M_FRAC;
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk(K_NUMBER, ts_q, p - one - ts_q, 1'b0, line_q);
          cand_v[1] = 1'b1;
          cand[1]   = mk(K_UNEXP, p - one, one, 1'b0, line_q);
          mode_d    = M_ERROR;
        end
      end
      M_FRAC: begin
        if (!is_digit(char_q)) begin
          cand_v[0] = 1'b1;
          cand[0]   = mk(K_NUMBER, ts_q, p - ts_q, 1'b1, line_q);
          st_go     = 1'b1;
        end
      end
      M_MINUS: begin
        if (is_digit(char_q)) begin
          mode_d = M_INT;
        end else if (ident_cont(char_q)) begin
          mode_d = M_IDENT;
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk(K_IDENT, ts_q, p - ts_q, 1'b0, line_q);
          st_go     = 1'b1;
        end
      end
      M_IDENT: begin
        if (!ident_cont(char_q)) begin
          cand_v[0] = 1'b1;
          cand[0]   = mk(K_IDENT, ts_q, p - ts_q, 1'b0, line_q);
          st_go     = 1'b1;
        end
      end
      M_STRING: begin
        if (char_q == CH_QUOTE) begin
          cand_v[0] = 1'b1;
          cand[0]   = mk(K_STRING, ts_q + one, p - ts_q - one, 1'b0, line_q);
          mode_d    = M_IDLE;
        end else if (char_q == CH_LF) begin
          line_d = line_inc(line_q);
        end
      end
      M_COMMENT: begin
        if (char_q == CH_LF) begin
          line_d = line_inc(line_q);
          mode_d = M_IDLE;
        end
      end
      M_ERROR: begin
      end
      default: st_go = 1'b1;
    endcase

    // this character opens a new token
    if (st_go) begin
      ts_d   = p;
      mode_d = M_IDLE;
      priority if (char_q == CH_LPAREN) begin
        cand_v[1] = 1'b1;
        cand[1]   = mk(K_LPAREN, p, one, 1'b0, line_q);
      end else if (char_q == CH_RPAREN) begin
        cand_v[1] = 1'b1;
        cand[1]   = mk(K_RPAREN, p, one, 1'b0, line_q);
      end else if (char_q == CH_SEMI) begin
        mode_d = M_COMMENT;
      end else if (char_q == CH_SPACE || char_q == CH_CR || char_q == CH_TAB) begin
      end else if (char_q == CH_LF) begin
        line_d = line_inc(line_q);
      end else if (char_q == CH_QUOTE) begin
        mode_d = M_STRING;
      end else if (is_digit(char_q)) begin
        mode_d = M_INT;
      end else if (char_q == CH_MINUS) begin
        mode_d = M_MINUS;
      end else if (ident_start(char_q)) begin
        mode_d = M_IDENT;
      end else begin
        cand_v[1] = 1'b1;
        cand[1]   = mk(K_UNEXP, p, one, 1'b0, line_q);
        mode_d    = M_ERROR;
      end
    end

    // end of text: close what is open, then the end word
    if (eot_q) begin
      unique case (mode_d)
        M_INT: begin
          cand_v[2] = 1'b1;
          cand[2]   = mk(K_NUMBER, ts_d, q - ts_d, 1'b0, line_d);
        end
        M_FRAC: begin
          cand_v[2] = 1'b1;
          cand[2]   = mk(K_NUMBER, ts_d, q - ts_d, 1'b1, line_d);
        end
        M_DOT: begin
          cand_v[2] = 1'b1;
          cand[2]   = mk(K_NUMBER, ts_d, q - one - ts_d, 1'b0, line_d);
          cand_v[3] = 1'b1;
          cand[3]   = mk(K_UNEXP, q - one, one, 1'b0, line_d);
        end
        M_MINUS, M_IDENT: begin
          cand_v[2] = 1'b1;
          cand[2]   = mk(K_IDENT, ts_d, q - ts_d, 1'b0, line_d);
        end
        M_STRING: begin
          cand_v[2] = 1'b1;
          cand[2]   = mk(K_UNTERM, ts_d + one, q - ts_d - one, 1'b0, line_d);
        end
        default: begin
        end
      endcase
      cand_v[4] = 1'b1;
      cand[4]   = mk(K_END, q, '0, 1'b0, line_d);
      mode_d    = M_IDLE;
      ts_d      = '0;
      pos_d     = '0;
      line_d    = OUT_W'(1);
    end
  end

  // pack the candidates in order; at most three are ever set
  always_comb begin
    n = '0;
    for (int i = 0; i < MAX_RES; i++) slot[i] = '0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_v[i] && n < 3'(MAX_RES)) begin
        slot[n[1:0]] = cand[i];
        n            = n + 3'd1;
      end
    end
    if (n != '0) slot[2'(n - 3'd1)].last = 1'b1;
  end

  assign push_n_o    = proc ? NUM_W'(n) : '0;
  assign push_data_o = slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      mode_q   <= M_IDLE;
      ts_q     <= '0;
      pos_q    <= '0;
      line_q   <= OUT_W'(1);
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (proc) begin
        in_vld_q <= 1'b0;
      end
      if (proc) begin
        mode_q <= mode_d;
        ts_q   <= ts_d;
        pos_q  <= pos_d;
        line_q <= line_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_code_i;
      eot_q  <= end_of_text_i;
    end
  end

endmodule

// ----- src/sts_result_fifo.sv -----
// Four-entry result queue, up to three words pushed and one popped per cycle.
module sts_result_fifo import sts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [NUM_W-1:0] push_n_i,
  input  res_t             push_data_i [MAX_RES],
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output res_t             out_data_o
);

  res_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign room_o      = cnt_q <= CNT_W'(FIFO_DEPTH - MAX_RES);
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = mem_q[rd_q];
  assign cnt_d       = cnt_q + CNT_W'(push_n_i) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PTR_W'(push_n_i);
      rd_q  <= rd_q + PTR_W'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (NUM_W'(k) < push_n_i) mem_q[wr_q + PTR_W'(k)] <= push_data_i[k];
    end
  end

endmodule

// ----- src/sexpr_token_scanner_unit.sv -----
// Top level of the s-expression token scanner: scan core plus result queue.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    char_code_i, end_of_text_i
//   out      output     out_valid_o / out_stall_i  token_kind_o .. last_of_item_o
//
// A character word is registered on acceptance and decoded from that register
// once the queue has room; its result words (zero to three) are written into
// a four-entry queue and reach the output from its registered entries.
// One character per cycle is taken while out_stall_i is low and each character
// yields at most one result; characters that yield two or three results are
// bounded by the output port, draining one result word per unstalled cycle.
// The decode stage runs only when the queue has room for three words; while
// it waits, in_stall_o is high and the held character stays registered.
// Reset (rst_ni low, asynchronous) empties the queue and sets idle mode,
// offset zero and line one. Queue contents and the character register are
// not reset.
module sexpr_token_scanner_unit import sts_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [15:0] line_number_o,
  output logic        has_fraction_o,
  output logic        last_of_item_o
);

  logic             room;
  logic [NUM_W-1:0] push_n;
  res_t             push_data [MAX_RES];
  res_t             out_data;

  // mode state and result generation
  sts_scan_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .end_of_text_i(end_of_text_i),
    .room_i       (room),
    .push_n_o     (push_n),
    .push_data_o  (push_data)
  );

  // result words wait here until the consumer takes them
  sts_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (push_n),
    .push_data_i(push_data),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign token_kind_o   = out_data.kind;
  assign start_offset_o = out_data.start;
  assign token_length_o = out_data.len;
  assign line_number_o  = out_data.line;
  assign has_fraction_o = out_data.frac;
  assign last_of_item_o = out_data.last;

endmodule

// ----- src/sts_checker.sv -----
// Port-level checks for the token scanner, bound to the top level.
module sts_checker import sts_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  token_kind_o,
  input logic [15:0] start_offset_o,
  input logic [15:0] token_length_o,
  input logic [15:0] line_number_o,
  input logic        has_fraction_o,
  input logic        last_of_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(start_offset_o) && $stable(token_length_o) && $stable(line_number_o))
    else $error("result word changed while stalled");

  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == K_END |->
      token_length_o == '0 && !has_fraction_o && last_of_item_o)
    else $error("malformed end word");

  a_frac_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_fraction_o |-> token_kind_o == K_NUMBER)
    else $error("fraction flag on a non-number");

  a_single_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == K_LPAREN || token_kind_o == K_RPAREN ||
      token_kind_o == K_UNEXP) |-> token_length_o == 16'd1)
    else $error("single-character word with wrong length");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_number_o != '0)
    else $error("line number zero");

endmodule

bind sexpr_token_scanner_unit sts_checker u_sts_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for the s-expression token scanner unit.
`timescale 1ns / 100ps

module tb;
  import sts_pkg::*;

  localparam int LIMIT     = 20000;   // cap on the monitor's cycle counter
  localparam int N_RANDOM  = 205;     // characters of random texts
  localparam int TAIL_WAIT = 12;      // extra wait after the last expected token word

  // Scanner modes of the predictor; they mirror the block's token modes.
  typedef enum logic [3:0] {
    SC_IDLE, SC_INT, SC_DOT, SC_FRAC, SC_MINUS, SC_IDENT, SC_STR, SC_CMT, SC_ERR
  } scan_e;

  // One pending character word; hold makes the driver wait for the scanner
  // to drain every expected token before sending it.
  typedef struct packed {
    logic [7:0] code;
    logic       eot;
    logic       hold;
  } char_word_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_code_i    = '0;
  logic        end_of_text_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [2:0]  token_kind_o;
  logic [15:0] start_offset_o;
  logic [15:0] token_length_o;
  logic [15:0] line_number_o;
  logic        has_fraction_o;
  logic        last_of_item_o;

  sexpr_token_scanner_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .line_number_o  (line_number_o),
    .has_fraction_o (has_fraction_o),
    .last_of_item_o (last_of_item_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Token predictor: its own copy of the scanner state, updated once per
  // accepted character word. Tokens of one character collect in step_q and
  // move to token_q with last_of_item set on the final one.
  // ---------------------------------------------------------------------
  scan_e       mode      = SC_IDLE;
  logic [15:0] tok_start = '0;
  logic [15:0] pos       = '0;
  logic [15:0] line_cnt  = 16'd1;

  res_t       step_q[$];
  res_t       token_q[$];   // tokens still owed by the scanner
  char_word_t pend_q[$];    // character words not yet sent

  function automatic logic dig_c(logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic let_c(logic [7:0] c);
    return (c inside {["A":"Z"]}) || (c inside {["a":"z"]});
  endfunction

  function automatic logic word_c(logic [7:0] c);
    return let_c(c) || dig_c(c) || c == CH_QMARK;
  endfunction

  function automatic void emit(kind_e k, logic [15:0] s, logic [15:0] l, logic f);
    res_t r;
    r.kind  = k;
    r.start = s;
    r.len   = l;
    r.line  = line_cnt;
    r.frac  = f;
    r.last  = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void bump_line();
    if (line_cnt != 16'hFFFF) line_cnt = line_cnt + 16'd1;
  endfunction

  function automatic void clear_scan();
    mode      = SC_IDLE;
    tok_start = '0;
    pos       = '0;
    line_cnt  = 16'd1;
  endfunction

  // Character seen with no token open.
  function automatic void open_token(logic [7:0] c, logic [15:0] p);
    tok_start = p;
    mode      = SC_IDLE;
    if (c == CH_LPAREN) emit(K_LPAREN, p, 16'd1, 1'b0);
    else if (c == CH_RPAREN) emit(K_RPAREN, p, 16'd1, 1'b0);
    else if (c == CH_SEMI) mode = SC_CMT;
    else if (c == CH_SPACE || c == CH_CR || c == CH_TAB) mode = SC_IDLE;
    else if (c == CH_LF) bump_line();
    else if (c == CH_QUOTE) mode = SC_STR;
    else if (dig_c(c)) mode = SC_INT;
    else if (c == CH_MINUS) mode = SC_MINUS;
    else if (let_c(c) || c inside {CH_PLUS, CH_STAR, CH_SLASH, CH_LT, CH_GT, CH_EQ})
      mode = SC_IDENT;
    else begin
      emit(K_UNEXP, p, 16'd1, 1'b0);
      mode = SC_ERR;
    end
  endfunction

  function automatic void lex_step(logic [7:0] c, logic eot);
    logic [15:0] p, ts, q;
    p  = pos;
    ts = tok_start;
    step_q.delete();
    case (mode)
      SC_INT: begin
        if (c == CH_DOT) mode = SC_DOT;
        else if (!dig_c(c)) begin
          emit(K_NUMBER, ts, p - ts, 1'b0);
          open_token(c, p);
        end
      end
      SC_DOT: begin
        if (dig_c(c)) mode = SC_FRAC;
        else begin
          // dot not followed by a digit: number ends before it, dot is an error
          emit(K_NUMBER, ts, p - 16'd1 - ts, 1'b0);
          emit(K_UNEXP, p - 16'd1, 16'd1, 1'b0);
          mode = SC_ERR;
        end
      end
      SC_FRAC: begin
        if (!dig_c(c)) begin
          emit(K_NUMBER, ts, p - ts, 1'b1);
          open_token(c, p);
        end
      end
      SC_MINUS: begin
        if (dig_c(c)) mode = SC_INT;
        else if (word_c(c)) mode = SC_IDENT;
        else begin
          emit(K_IDENT, ts, p - ts, 1'b0);
          open_token(c, p);
        end
      end
      SC_IDENT: begin
        if (!word_c(c)) begin
          emit(K_IDENT, ts, p - ts, 1'b0);
          open_token(c, p);
        end
      end
      SC_STR: begin
        if (c == CH_QUOTE) begin
          emit(K_STRING, ts + 16'd1, p - ts - 16'd1, 1'b0);
          mode = SC_IDLE;
        end else if (c == CH_LF) bump_line();
      end
      SC_CMT: begin
        if (c == CH_LF) begin
          bump_line();
          mode = SC_IDLE;
        end
      end
      SC_ERR: ;
      default: open_token(c, p);
    endcase
    pos = p + 16'd1;

    // End of text closes any open token, then the end token; state restarts.
    if (eot) begin
      q  = pos;
      ts = tok_start;
      case (mode)
        SC_INT:  emit(K_NUMBER, ts, q - ts, 1'b0);
        SC_FRAC: emit(K_NUMBER, ts, q - ts, 1'b1);
        SC_DOT: begin
          emit(K_NUMBER, ts, q - 16'd1 - ts, 1'b0);
          emit(K_UNEXP, q - 16'd1, 16'd1, 1'b0);
        end
        SC_MINUS, SC_IDENT: emit(K_IDENT, ts, q - ts, 1'b0);
        SC_STR: emit(K_UNTERM, ts + 16'd1, q - ts - 16'd1, 1'b0);
        default: ;
      endcase
      emit(K_END, q, 16'd0, 1'b0);
      clear_scan();
    end

    foreach (step_q[i]) begin
      res_t r;
      r      = step_q[i];
      r.last = (i == step_q.size() - 1);
      token_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------
  int n_items = 0;

  function automatic void push_byte(logic [7:0] c, logic eot, logic hold);
    char_word_t w;
    w.code = c;
    w.eot  = eot;
    w.hold = hold;
    pend_q.push_back(w);
    n_items++;
  endfunction

  function automatic void push_text(string s, logic hold);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], i == s.len() - 1, hold && i == 0);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = $urandom_range(0, 1) ? "a" : "A";
    return c + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  // One random text of 1..8 mostly well-formed tokens; a share of noise
  // bytes, broken fractions and unclosed strings. Returns its length.
  function automatic int push_rand_text(logic hold);
    logic [7:0] txt[$];
    logic [7:0] ops[7];
    logic [7:0] ws[4];
    int ntok;
    ops  = '{CH_PLUS, CH_STAR, CH_SLASH, CH_LT, CH_GT, CH_EQ, CH_MINUS};
    ws   = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
    ntok = $urandom_range(1, 8);
    for (int k = 0; k < ntok; k++) begin
      case ($urandom_range(0, 11))
        0: txt.push_back(CH_LPAREN);
        1: txt.push_back(CH_RPAREN);
        2: begin
          if ($urandom_range(0, 1)) txt.push_back(CH_MINUS);
          repeat ($urandom_range(1, 3)) txt.push_back(rand_digit());
          if ($urandom_range(0, 2) == 0) begin
            txt.push_back(CH_DOT);
            repeat ($urandom_range(1, 2)) txt.push_back(rand_digit());
          end
        end
        3: begin
          txt.push_back($urandom_range(0, 2) == 0 ? ops[$urandom_range(0, 6)]
                                                  : rand_letter());
          repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
              0:       txt.push_back(rand_digit());
              1:       txt.push_back(CH_QMARK);
              default: txt.push_back(rand_letter());
            endcase
          end
        end
        4: begin
          txt.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 3))
            txt.push_back($urandom_range(0, 3) == 0 ? CH_LF : rand_letter());
          // sometimes left open: the string swallows the rest of the text
          if ($urandom_range(0, 7) != 0) txt.push_back(CH_QUOTE);
        end
        5: txt.push_back(ws[$urandom_range(0, 3)]);
        6: begin
          txt.push_back(CH_SEMI);
          repeat ($urandom_range(0, 3)) txt.push_back(rand_letter());
          txt.push_back(CH_LF);
        end
        7: txt.push_back(CH_LF);
        8: txt.push_back(8'($urandom_range(0, 255)));
        9: begin
          txt.push_back(rand_digit());
          txt.push_back(CH_DOT);
          if ($urandom_range(0, 1)) txt.push_back(rand_letter());
        end
        default: txt.push_back(CH_SPACE);
      endcase
      if ($urandom_range(0, 1)) txt.push_back(CH_SPACE);
    end
    foreach (txt[i]) push_byte(txt[i], i == txt.size() - 1, hold && i == 0);
    return txt.size();
  endfunction

  // ---------------------------------------------------------------------
  // Driver and monitor
  // ---------------------------------------------------------------------
  int   chars_taken = 0;
  int   cycles      = 0;
  int   err_cnt     = 0;
  logic took_word   = 1'b0;
  logic calm;
  res_t want;

  // No idling on either side for a stretch of the random texts.
  assign calm = (chars_taken >= 100) && (chars_taken < 170);

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("tb: %s", msg);
  endfunction

  // Sender: a word stays on the port until it is taken.
  always @(negedge clk_i) begin
    char_word_t w;
    if (rst_ni) begin
      if (!in_valid_i || took_word) begin
        if (pend_q.size() != 0 && !(pend_q[0].hold && token_q.size() != 0) &&
            (calm || $urandom_range(0, 99) >= 10)) begin
          w = pend_q.pop_front();
          char_code_i   <= w.code;
          end_of_text_i <= w.eot;
          in_valid_i    <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 10);
    end
  end

  // Monitor: compare token words in order, predict from accepted characters.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
    if (out_valid_o && !out_stall_i) begin
      if (token_q.size() == 0) begin
        note_error($sformatf("token word with none expected: kind %0d start %0d len %0d",
                             token_kind_o, start_offset_o, token_length_o));
      end else begin
        want = token_q.pop_front();
        if (token_kind_o !== want.kind || start_offset_o !== want.start ||
            token_length_o !== want.len || line_number_o !== want.line ||
            has_fraction_o !== want.frac || last_of_item_o !== want.last)
          note_error($sformatf(
            "mismatch k/s/l/ln/f/e exp %0d/%0d/%0d/%0d/%b/%b got %0d/%0d/%0d/%0d/%b/%b",
            want.kind, want.start, want.len, want.line, want.frac, want.last,
            token_kind_o, start_offset_o, token_length_o, line_number_o,
            has_fraction_o, last_of_item_o));
      end
    end
    took_word = in_valid_i && !in_stall_o;
    if (took_word) begin
      lex_step(char_code_i, end_of_text_i);
      chars_taken++;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: directed texts, random texts, then drain.
  // ---------------------------------------------------------------------
  initial begin
    int n_rand;
    // Directed: all kinds but a closed string, fraction, identifier with '?', closing
    // paren right after an identifier (three words from one character).
    push_text("(-3.25 x?)", 1'b0);
    // dot without digit: number, error and end all from the last character
    push_text("1.x", 1'b0);
    // unterminated string with a newline in it
    push_text("\"a\n", 1'b0);
    // lowest and highest bytes are unexpected characters
    push_byte(8'h00, 1'b1, 1'b0);
    // comment up to a newline, then a lone minus closed by end of text
    push_text("; \n-", 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    // text ending right after a dot
    push_text("7.", 1'b0);

    // Random texts; the first waits for the directed tokens to drain.
    n_rand = 0;
    while (n_rand < N_RANDOM) n_rand += push_rand_text(n_rand == 0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (chars_taken != n_items) @(negedge clk_i);
    while (token_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_WAIT) @(negedge clk_i);

    if (err_cnt == 0 && token_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
